>>> hw/rtl/b64lw_pkg.sv
// Package for the line-wrapping base64 encoder.
// Holds the item, configuration and group types, the character constants and the alphabet.
// No dependencies.
package b64lw_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WRAP_ENABLE = 2'd0;
    localparam logic [1:0] CFG_LINE_LIMIT  = 2'd1;

    // Register reset values.
    localparam logic       WRAP_ENABLE_RST = 1'b1;
    localparam logic [7:0] LINE_LIMIT_RST  = 8'd72;

    // Special characters.
    localparam logic [7:0] CH_PAD = 8'h3D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    // Most characters one input item can cause: four plus a line feed.
    localparam int unsigned MAX_CHARS = 5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_end;
        logic       stream_done;
    } t_out_item;

    typedef struct packed {
        logic       wrap_enable;
        logic [7:0] line_limit;
    } t_cfg;

    // All characters caused by one input item, ready to be sent in order.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [2:0]                count;
        logic                      last;
    } t_group;

    // Maps a six-bit value to its character of the standard alphabet.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        case (v) inside
            [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
            [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
            [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
            6'd62:         c = 8'h2B;
            default:       c = 8'h2F;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/b64lw_encode.sv
// Encode stage: input register, held bytes, group fill and line count.
// Turns one input item into a group of up to five characters in one pass.
// Depends on b64lw_pkg.
module b64lw_encode
    import b64lw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_grp_ready,
    output logic     o_grp_load,
    output t_group   o_grp
);

    logic       r_in_valid;
    t_in_item   r_in;
    logic [7:0] r_held0, r_held1;
    logic [1:0] r_fill;
    logic [7:0] r_line_count;

    logic [7:0] n_held0, n_held1;
    logic [1:0] n_fill;
    logic [7:0] n_line_count;
    logic [8:0] lc_sum;
    logic [7:0] lc_sat;
    logic [7:0] lc_after;
    logic [7:0] b;
    t_group     grp;
    logic       adv;

    // Build the group of characters and the next state from the held item.
    always_comb begin
        b        = r_in.data_byte;
        grp      = '0;
        grp.last = r_in.last_byte;
        n_held0  = r_held0;
        n_held1  = r_held1;
        n_fill   = r_fill;
        lc_sum   = {1'b0, r_line_count} + 9'd4;
        lc_sat   = lc_sum[8] ? 8'hFF : lc_sum[7:0];
        lc_after = r_line_count;

        if (r_fill == 2'd2) begin
            // Full group of three bytes.
            grp.chars[0] = b64_char(r_held0[7:2]);
            grp.chars[1] = b64_char({r_held0[1:0], r_held1[7:4]});
            grp.chars[2] = b64_char({r_held1[3:0], b[7:6]});
            grp.chars[3] = b64_char(b[5:0]);
            grp.count    = 3'd4;
            n_fill       = 2'd0;
            lc_after     = lc_sat;
            if (i_cfg.wrap_enable && (lc_sat >= i_cfg.line_limit)) begin
                grp.chars[4] = CH_LF;
                grp.count    = 3'd5;
                lc_after     = 8'd0;
            end
        end else if (!r_in.last_byte) begin
            // Collect the byte and wait for the rest of the group.
            if (r_fill[0]) begin
                n_held1 = b;
            end else begin
                n_held0 = b;
            end
            n_fill = r_fill + 2'd1;
        end else begin
            // Padded tail group of one or two bytes.
            if (r_fill == 2'd0) begin
                grp.chars[0] = b64_char(b[7:2]);
                grp.chars[1] = b64_char({b[1:0], 4'b0000});
                grp.chars[2] = CH_PAD;
            end else begin
                grp.chars[0] = b64_char(r_held0[7:2]);
                grp.chars[1] = b64_char({r_held0[1:0], b[7:4]});
                grp.chars[2] = b64_char({b[3:0], 2'b00});
            end
            grp.chars[3] = CH_PAD;
            grp.count    = 3'd4;
            n_fill       = 2'd0;
            lc_after     = lc_sat;
        end

        n_line_count = lc_after;
        if (r_in.last_byte) begin
            // With wrapping on, a non-empty last line is closed by a line feed; the count is then
            // never zero with four characters in the group and no line feed yet.
            if (i_cfg.wrap_enable && (lc_after != 8'd0)) begin
                grp.chars[4] = CH_LF;
                grp.count    = 3'd5;
            end
            n_held0      = 8'd0;
            n_held1      = 8'd0;
            n_fill       = 2'd0;
            n_line_count = 8'd0;
        end
    end

    // An item leaves the input register once its group has a place to go.
    assign adv        = r_in_valid && ((grp.count == 3'd0) || i_grp_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign o_grp_load = adv && (grp.count != 3'd0);
    assign o_grp      = grp;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    // Encoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held0      <= 8'd0;
            r_held1      <= 8'd0;
            r_fill       <= 2'd0;
            r_line_count <= 8'd0;
        end else if (adv) begin
            r_held0      <= n_held0;
            r_held1      <= n_held1;
            r_fill       <= n_fill;
            r_line_count <= n_line_count;
        end
    end

    // The group fill never reaches three.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3)
        else $error("group fill out of range");

    // The end of a stream leaves no bytes held and an empty line.
    a_stream_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.last_byte) |=> (r_fill == 2'd0 && r_line_count == 8'd0))
        else $error("state not cleared at stream end");

endmodule

>>> hw/rtl/b64lw_serial.sv
// Result register: holds one group of characters and sends them one per cycle while the receiver is ready.
// Marks the last character of each group and of each stream.
// Depends on b64lw_pkg.
module b64lw_serial
    import b64lw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_grp_load,
    input  t_group    i_grp,
    output logic      o_grp_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic                      r_valid;
    logic [MAX_CHARS-1:0][7:0] r_chars;
    logic [2:0]                r_cnt;
    logic [2:0]                r_idx;
    logic                      r_last;

    logic at_end;
    logic take;

    // Position of the current character within its group.
    assign at_end      = (r_idx == (r_cnt - 3'd1));
    assign take        = r_valid && i_out_ready;
    assign o_grp_ready = !r_valid || (i_out_ready && at_end);

    assign o_out_valid            = r_valid;
    assign o_out_item.out_char    = r_chars[r_idx];
    assign o_out_item.run_end     = at_end;
    assign o_out_item.stream_done = at_end && r_last;

    // Control: valid flag and character index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (i_grp_load) begin
            r_valid <= 1'b1;
            r_idx   <= 3'd0;
        end else if (take && at_end) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    // Payload of the group.
    always_ff @(posedge i_clk) begin
        if (i_grp_load) begin
            r_chars <= i_grp.chars;
            r_cnt   <= i_grp.count;
            r_last  <= i_grp.last;
        end
    end

    // A held group has between one and five characters and the index stays inside it.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_cnt != 3'd0 && r_cnt <= 3'd5 && r_idx < r_cnt))
        else $error("character index outside its group");

    // A new group is loaded only when the previous one is gone or finishing.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_grp_load |-> (!r_valid || (take && at_end)))
        else $error("group overwritten before it was sent");

endmodule

>>> hw/rtl/base64_line_wrapping_encoder_top.sv
// Top level of the line-wrapping base64 encoder.
// Holds the configuration registers and joins the encode stage to the result register.
// Depends on b64lw_pkg, b64lw_encode and b64lw_serial.
//
// Usage: bytes enter on the input channel (valid/ready), one item per byte, with
// last_byte set on the final byte of a stream. Characters leave on the output
// channel, one item per character, with run_end on the last character caused by
// an input item and stream_done on the final character of the stream.
// The first character of an item reaches the output through the input register and
// then the result register, which takes the group once its previous group is done.
// Every third byte of a group causes four characters, or five with a line feed;
// a final byte that leaves a group partial causes four characters with padding, or
// five with the closing line feed; other bytes cause none. The output sends one
// character a cycle while the receiver is ready, so the result register sets the rate.
// Configuration (wrap enable, line limit) is to be written through the write port only
// while the block is idle; the block does not enforce this. Reset clears the held
// bytes, the line count and both channels and loads wrap enable 1 and line limit 72.
// When the receiver stalls, the current character holds; bytes that only fill
// the group are still taken, and input ready drops once a byte that completes
// a group waits in the input register behind the group being sent.
module base64_line_wrapping_encoder_top
    import b64lw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic   r_wrap_enable;
    logic [7:0] r_line_limit;
    t_cfg   cfg;
    logic   grp_load;
    logic   grp_ready;
    t_group grp;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_enable <= WRAP_ENABLE_RST;
            r_line_limit  <= LINE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WRAP_ENABLE: r_wrap_enable <= i_cfg_data[0];
                CFG_LINE_LIMIT:  r_line_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.wrap_enable = r_wrap_enable;
    assign cfg.line_limit  = r_line_limit;

    b64lw_encode u_encode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_grp_ready (grp_ready),
        .o_grp_load  (grp_load),
        .o_grp       (grp)
    );

    b64lw_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_load  (grp_load),
        .i_grp       (grp),
        .o_grp_ready (grp_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

>>> dv/b64lw_stream_checker.sv
// Checker for the line-wrapping base64 encoder: watches the configuration port and both channels.
// Predicts the characters of every accepted byte and compares them with the output items.
// Depends on b64lw_pkg.
module b64lw_stream_checker
    import b64lw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in_item,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out_item,
    output int         o_fail_count,
    output int         o_pending
);

    string b64_symbols = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Characters predicted but not yet seen on the output channel, oldest first.
    t_out_item expected_chars [$];

    // Predicted encoder state and configuration.
    logic [7:0] held_bytes [2];
    logic [1:0] group_fill;
    logic [7:0] line_count;
    logic       wrap_on;
    logic [7:0] line_limit;

    t_out_item want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [7:0] symbol_of(input logic [5:0] v);
        return b64_symbols[v];
    endfunction

    task automatic report_mismatch(input string what);
        o_fail_count++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    // Works out the characters one accepted byte causes and queues them in order.
    task automatic encode_byte(input logic [7:0] b, input logic last);
        logic [7:0] run_chars [$];
        logic [7:0] b0;
        t_out_item  entry;
        if (group_fill >= 2'd2) begin
            // The third byte completes a group of four characters.
            b0 = held_bytes[0];
            run_chars.push_back(symbol_of(b0[7:2]));
            run_chars.push_back(symbol_of({b0[1:0], held_bytes[1][7:4]}));
            run_chars.push_back(symbol_of({held_bytes[1][3:0], b[7:6]}));
            run_chars.push_back(symbol_of(b[5:0]));
            group_fill = 2'd0;
            line_count = (line_count > 8'd251) ? 8'd255 : line_count + 8'd4;
            if (wrap_on && line_count >= line_limit) begin
                run_chars.push_back(CH_LF);
                line_count = 8'd0;
            end
        end else if (!last) begin
            held_bytes[group_fill[0]] = b;
            group_fill = group_fill + 2'd1;
        end else begin
            // Stream ends on a partial group: pad it out to four characters.
            b0 = (group_fill == 2'd0) ? b : held_bytes[0];
            run_chars.push_back(symbol_of(b0[7:2]));
            if (group_fill == 2'd0) begin
                run_chars.push_back(symbol_of({b0[1:0], 4'b0000}));
                run_chars.push_back(CH_PAD);
            end else begin
                run_chars.push_back(symbol_of({b0[1:0], b[7:4]}));
                run_chars.push_back(symbol_of({b[3:0], 2'b00}));
            end
            run_chars.push_back(CH_PAD);
            group_fill = 2'd0;
            line_count = (line_count > 8'd251) ? 8'd255 : line_count + 8'd4;
        end

        // With wrapping on, the end of a stream closes a non-empty line; it always clears the state.
        if (last) begin
            if (wrap_on && line_count != 8'd0) begin
                run_chars.push_back(CH_LF);
            end
            held_bytes[0] = 8'd0;
            held_bytes[1] = 8'd0;
            group_fill    = 2'd0;
            line_count    = 8'd0;
        end

        foreach (run_chars[i]) begin
            entry.out_char    = run_chars[i];
            entry.run_end     = (i == run_chars.size() - 1);
            entry.stream_done = last && (i == run_chars.size() - 1);
            expected_chars.push_back(entry);
        end
    endtask

    // Output items are checked before new bytes are predicted, so an early item cannot hide.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_bytes[0] = 8'd0;
            held_bytes[1] = 8'd0;
            group_fill    = 2'd0;
            line_count    = 8'd0;
            wrap_on       = WRAP_ENABLE_RST;
            line_limit    = LINE_LIMIT_RST;
            expected_chars.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("character %02h with nothing expected",
                                              i_out_item.out_char));
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out_item.out_char !== want.out_char) begin
                        report_mismatch($sformatf("out_char %02h, expected %02h",
                                                  i_out_item.out_char, want.out_char));
                    end
                    if (i_out_item.run_end !== want.run_end) begin
                        report_mismatch($sformatf("run_end %b, expected %b",
                                                  i_out_item.run_end, want.run_end));
                    end
                    if (i_out_item.stream_done !== want.stream_done) begin
                        report_mismatch($sformatf("stream_done %b, expected %b",
                                                  i_out_item.stream_done, want.stream_done));
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WRAP_ENABLE: wrap_on = i_cfg_data[0];
                    CFG_LINE_LIMIT:  line_limit = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                encode_byte(i_in_item.data_byte, i_in_item.last_byte);
            end
        end
        o_pending = expected_chars.size();
    end

endmodule

>>> dv/base64_line_wrapping_encoder_top_tb.sv
// Testbench top for the line-wrapping base64 encoder: clock, reset, byte streams and verdict.
// Directed streams cover tails, line limits and wrap changes; random streams follow.
// Depends on b64lw_pkg, base64_line_wrapping_encoder_top and b64lw_stream_checker.
module base64_line_wrapping_encoder_top_tb;
    import b64lw_pkg::*;

    // Register indexes the block has no register for; writes to them are ignored.
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    localparam int unsigned RANDOM_BYTES = 185;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned DRAIN_LIMIT  = 200000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [7:0] cfg_data  = 8'd0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in_item   in_item   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;
    int         fail_count;
    int         pending;

    // Both sides idle at random unless steady is set; hold_long asks for a long receiver stall.
    bit steady    = 1'b0;
    bit hold_long = 1'b0;

    base64_line_wrapping_encoder_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    b64lw_stream_checker stream_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(8 * 1000000);
        $display("base64_line_wrapping_encoder_top verification failed");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Receiver: random stalls, plus one long stall on request.
    initial begin
        int unsigned gap;
        forever begin
            if (hold_long) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_long = 1'b0;
            end
            gap = steady ? 0 : pick_gap();
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        in_item  <= {b, last};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_stream(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every predicted character has arrived and the block has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    initial begin
        int unsigned sent;
        int unsigned len;
        int unsigned waited;
        logic [7:0]  reg_value;
        bit          pressure_done;

        pressure_done = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tails after reset: one byte, two bytes, then a full group that ends the stream.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        settle();

        // Lowest limit in range: a line feed after every group.
        write_reg(CFG_LINE_LIMIT, 8'd4);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b1);
        settle();

        // Limit of zero: the group line feed leaves nothing for the closing one.
        write_reg(CFG_LINE_LIMIT, 8'd0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);
        settle();

        // Wrap off via a value with upper bits set; writes to spare indexes change nothing.
        write_reg(CFG_WRAP_ENABLE, 8'hFE);
        write_reg(CFG_LINE_LIMIT, 8'hFF);
        write_reg(CFG_SPARE_2, 8'h01);
        write_reg(CFG_SPARE_3, 8'h00);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b1);
        settle();

        // Wrap switched on mid-stream with the line already at the limit.
        write_reg(CFG_LINE_LIMIT, 8'd8);
        repeat (6) send_byte(8'($urandom_range(0, 255)), 1'b0);
        settle();
        write_reg(CFG_WRAP_ENABLE, 8'h01);
        repeat (2) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        settle();

        // Random streams under random settings, most of them short.
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            reg_value    = 8'($urandom_range(0, 255));
            reg_value[0] = ($urandom_range(0, 3) != 0);
            write_reg(CFG_WRAP_ENABLE, reg_value);
            case ($urandom_range(0, 5))
                0: reg_value = 8'd4;
                1: reg_value = 8'd252;
                2: reg_value = 8'($urandom_range(4, 20));
                3: reg_value = 8'($urandom_range(4, 252));
                4: reg_value = 8'($urandom_range(0, 3));
                default: reg_value = 8'($urandom_range(253, 255));
            endcase
            write_reg(CFG_LINE_LIMIT, reg_value);
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4)) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
                send_stream(len);
                sent += len;
            end

            // Once, the receiver stalls for a long time while bytes keep coming.
            if (sent >= RANDOM_BYTES / 2 && !pressure_done) begin
                steady    = 1'b1;
                hold_long = 1'b1;
                send_stream(30);
                sent += 30;
                pressure_done = 1'b1;
            end
            settle();
        end
        steady = 1'b0;

        // Drain whatever is still expected, with a bound.
        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("base64_line_wrapping_encoder_top verification clean");
        end else begin
            $display("base64_line_wrapping_encoder_top verification failed");
        end
        $finish;
    end

endmodule
